// ===== design/oad_pkg.sv =====
// ----------------------------------------------------------------------------
// oad_pkg: shared types and constants for the obstacle avoidance drive core
// Task codes, item kinds, drive modes, range thresholds and speed constants.
// ----------------------------------------------------------------------------
package oad_pkg;

    // Task sequence: start phase (even) and running phase (odd) of each move
    typedef enum logic [3:0] {
        TASK_WAIT        = 4'd0,
        TASK_WAITING     = 4'd1,
        TASK_ADVANCE     = 4'd2,
        TASK_ADVANCING   = 4'd3,
        TASK_TURN_L      = 4'd4,
        TASK_TURNING_L   = 4'd5,
        TASK_TURN_R      = 4'd6,
        TASK_TURNING_R   = 4'd7,
        TASK_SPIN_L      = 4'd8,
        TASK_SPINNING_L  = 4'd9,
        TASK_SPIN_R      = 4'd10,
        TASK_SPINNING_R  = 4'd11,
        TASK_SLOW        = 4'd12,
        TASK_SLOWING     = 4'd13
    } task_t;

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_LOOP = 2'd0;
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Drive modes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CRUISE = 2'd0;
    localparam logic [1:0] CFG_CRAWL  = 2'd1;
    localparam logic [1:0] CFG_DELAY  = 2'd2;

    localparam logic [6:0]  CRUISE_RESET = 7'd50;
    localparam logic [6:0]  CRAWL_RESET  = 7'd20;
    localparam logic [15:0] DELAY_RESET  = 16'd2000;
    localparam logic [15:0] MS_MAX       = 16'hFFFF;

    // Range thresholds in cm
    localparam logic [7:0] RANGE_NEAR  = 8'd40;
    localparam logic [7:0] RANGE_CLOSE = 8'd20;
    localparam logic [7:0] RANGE_SIDE  = 8'd15;
    localparam logic [7:0] RANGE_DIAG  = 8'd25;

    // Speed constants in signed percent
    localparam logic [6:0]        SPEED_MAX  = 7'd100;
    localparam logic signed [7:0] TURN_FAST  = 8'sd55;
    localparam logic signed [7:0] TURN_SLOW  = 8'sd30;
    localparam logic signed [7:0] SPIN_POS   = 8'sd25;
    localparam logic signed [7:0] SPIN_NEG   = -8'sd25;

    typedef struct packed {
        logic [7:0] right;
        logic [7:0] front_right;
        logic [7:0] front;
        logic [7:0] front_left;
        logic [7:0] left;
    } ranges_t;

    typedef struct packed {
        logic [6:0]  cruise_speed;
        logic [6:0]  crawl_speed;
        logic [15:0] start_delay;
    } cfg_t;

    typedef struct packed {
        logic signed [7:0] right_speed;
        logic signed [7:0] left_speed;
        task_t             task_code;
    } result_t;

    // Clamp a speed register to 100 percent
    function automatic logic [6:0] sat100(input logic [6:0] v);
        sat100 = (v > SPEED_MAX) ? SPEED_MAX : v;
    endfunction

endpackage

// ===== design/oad_classify.sv =====
// ----------------------------------------------------------------------------
// oad_classify: obstacle classifier
// Compares the five range readings with fixed thresholds, and right with left,
// and picks the start code of the next manoeuvre.
// ----------------------------------------------------------------------------
module oad_classify (
    input  oad_pkg::ranges_t ranges,
    output oad_pkg::task_t   choice
);
    import oad_pkg::*;

    logic slow_zone;

    // Anything near in front or on the right, or close on the left, calls for slowing down
    assign slow_zone = (ranges.front < RANGE_NEAR) || (ranges.right < RANGE_NEAR) ||
                       (ranges.left < RANGE_CLOSE);

    // Pick the manoeuvre; earlier tests win
    always_comb begin
        priority if (ranges.front < RANGE_CLOSE) begin
            choice = (ranges.right < ranges.left) ? TASK_SPIN_L : TASK_SPIN_R;
        end else if (ranges.right < RANGE_SIDE) begin
            choice = TASK_TURN_L;
        end else if (ranges.left < RANGE_SIDE) begin
            choice = TASK_TURN_R;
        end else if (ranges.front_right < RANGE_DIAG) begin
            choice = TASK_TURN_L;
        end else if (ranges.front_left < RANGE_DIAG) begin
            choice = TASK_TURN_R;
        end else if ((ranges.front > RANGE_NEAR) && (ranges.right > RANGE_NEAR) &&
                     (ranges.left > RANGE_NEAR)) begin
            choice = TASK_ADVANCE;
        end else begin
            choice = slow_zone ? TASK_SLOW : TASK_ADVANCE;
        end
    end

endmodule

// ===== design/oad_seq.sv =====
// ----------------------------------------------------------------------------
// oad_seq: task sequencer
// Holds task, mode, millisecond counter and wheel commands, and updates them
// for one item per cycle while step_en is high. Presents the state after the item.
// ----------------------------------------------------------------------------
module oad_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [1:0]       kind,
    input  logic [1:0]       mode_value,
    input  logic             forward,
    input  oad_pkg::ranges_t ranges,
    input  oad_pkg::cfg_t    cfg,
    output oad_pkg::result_t result_next
);
    import oad_pkg::*;

    task_t             task_reg, task_next;
    logic [1:0]        mode_reg, mode_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic signed [7:0] right_reg, right_next;
    logic signed [7:0] left_reg, left_next;
    task_t             choice;
    logic signed [7:0] adv_speed;
    logic signed [7:0] crawl;
    logic              running;

    oad_classify u_classify (
        .ranges (ranges),
        .choice (choice)
    );

    // Advance speed, negated when driving backward
    always_comb begin
        adv_speed = $signed({1'b0, sat100(cfg.cruise_speed)});
        if (!forward) begin
            adv_speed = -adv_speed;
        end
    end
    assign crawl = $signed({1'b0, sat100(cfg.crawl_speed)});

    assign running = (task_reg == TASK_ADVANCING) || (task_reg == TASK_TURNING_L) ||
                     (task_reg == TASK_TURNING_R) || (task_reg == TASK_SPINNING_L) ||
                     (task_reg == TASK_SPINNING_R) || (task_reg == TASK_SLOWING);

    // Next state: task, mode and counter
    always_comb begin
        task_next    = task_reg;
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        unique case (kind)
            KIND_LOOP: begin
                if (running) begin
                    // keep the task when the choice is the move already running
                    if ((mode_reg == MODE_AUTO) &&
                        ((4'(choice) + 4'd1) != 4'(task_reg))) begin
                        task_next = choice;
                    end
                end else begin
                    unique case (task_reg)
                        TASK_WAIT:    if (mode_reg == MODE_AUTO) task_next = TASK_WAITING;
                        TASK_WAITING: if (elapsed_reg > cfg.start_delay)
                                          task_next = TASK_ADVANCE;
                        TASK_ADVANCE: task_next = TASK_ADVANCING;
                        TASK_TURN_L:  task_next = TASK_TURNING_L;
                        TASK_TURN_R:  task_next = TASK_TURNING_R;
                        TASK_SPIN_L:  task_next = TASK_SPINNING_L;
                        TASK_SPIN_R:  task_next = TASK_SPINNING_R;
                        TASK_SLOW:    task_next = TASK_SLOWING;
                        default:      task_next = TASK_WAIT;
                    endcase
                end
            end
            KIND_MODE: begin
                mode_next = mode_value;
                task_next = TASK_WAIT;
                if (mode_value == MODE_OFF) begin
                    elapsed_next = '0;
                end
            end
            KIND_TICK: begin
                if (elapsed_reg != MS_MAX) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Outputs: wheel commands, set in start phases, zeroed on mode items and held otherwise
    always_comb begin
        right_next = right_reg;
        left_next  = left_reg;
        unique case (kind)
            KIND_LOOP: begin
                unique case (task_reg)
                    TASK_WAIT: begin
                        right_next = '0;
                        left_next  = '0;
                    end
                    TASK_ADVANCE: begin
                        right_next = adv_speed;
                        left_next  = adv_speed;
                    end
                    TASK_TURN_L: begin
                        right_next = TURN_FAST;
                        left_next  = TURN_SLOW;
                    end
                    TASK_TURN_R: begin
                        right_next = TURN_SLOW;
                        left_next  = TURN_FAST;
                    end
                    TASK_SPIN_L: begin
                        right_next = SPIN_POS;
                        left_next  = SPIN_NEG;
                    end
                    TASK_SPIN_R: begin
                        right_next = SPIN_NEG;
                        left_next  = SPIN_POS;
                    end
                    TASK_SLOW: begin
                        right_next = crawl;
                        left_next  = crawl;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_MODE: begin
                right_next = '0;
                left_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // Commit the update when an item moves through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_reg    <= TASK_WAIT;
            mode_reg    <= MODE_OFF;
            elapsed_reg <= '0;
            right_reg   <= '0;
            left_reg    <= '0;
        end else if (step_en) begin
            task_reg    <= task_next;
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            right_reg   <= right_next;
            left_reg    <= left_next;
        end
    end

    assign result_next.right_speed = right_next;
    assign result_next.left_speed  = left_next;
    assign result_next.task_code   = task_next;

endmodule

// ===== design/obstacle_avoid_drive_fsm_core.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm_core: two-wheel obstacle avoidance drive sequencer
// Input register, state update, result register.
//
//   Channel | Ports         | Contents
//   input   | s_t*          | tuser: kind; tdata: mode, forward, five ranges
//   result  | m_t*          | tdata: right speed, left speed, task code
//   config  | cfg_*         | cruise speed, crawl speed, start delay
//
// One item per cycle unless the result stalls; an accepted item goes through the input
// register and the state update, which sets the rate, into the result register.
// Reset (synchronous, active low) returns to wait, mode off, speeds zero.
// A stalled result holds both registers; the input register still takes an
// item while it is empty.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_fsm_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode_value, [2] forward, [10:3] range_right, [18:11] range_front_right,
    // [26:19] range_front, [34:27] range_front_left, [42:35] range_left
    input  logic [47:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] right_speed, [15:8] left_speed, [19:16] task_code
    output logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import oad_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [1:0] in_mode_reg;
    logic       in_fwd_reg;
    ranges_t    in_ranges_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result_next;
    cfg_t       cfg_reg;
    logic       step_en;
    logic       in_take;

    // Move an item forward when the result register is free or being read
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cruise_speed <= CRUISE_RESET;
            cfg_reg.crawl_speed  <= CRAWL_RESET;
            cfg_reg.start_delay  <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CRUISE: cfg_reg.cruise_speed <= cfg_wdata[6:0];
                CFG_CRAWL:  cfg_reg.crawl_speed  <= cfg_wdata[6:0];
                CFG_DELAY:  cfg_reg.start_delay  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg               <= s_tuser;
            in_mode_reg               <= s_tdata[1:0];
            in_fwd_reg                <= s_tdata[2];
            in_ranges_reg.right       <= s_tdata[10:3];
            in_ranges_reg.front_right <= s_tdata[18:11];
            in_ranges_reg.front       <= s_tdata[26:19];
            in_ranges_reg.front_left  <= s_tdata[34:27];
            in_ranges_reg.left        <= s_tdata[42:35];
        end
    end

    oad_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .kind        (in_kind_reg),
        .mode_value  (in_mode_reg),
        .forward     (in_fwd_reg),
        .ranges      (in_ranges_reg),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    // Result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, 4'(out_reg.task_code), out_reg.left_speed, out_reg.right_speed};

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Waiting for the start delay always has the wheels stopped
    a_waiting_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[19:16] == 4'(TASK_WAITING))) |->
        (m_tdata[15:0] == 16'd0))
        else $error("wheels moving while waiting for start");

    // Spinning left keeps the spin speeds set at its start
    a_spin_left_speeds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[19:16] == 4'(TASK_SPINNING_L))) |->
        ((m_tdata[7:0] == SPIN_POS) && (m_tdata[15:8] == SPIN_NEG)))
        else $error("spin left running with wrong speeds");

    // A stalled result stays valid and unchanged until it is read
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result overwritten");

endmodule
